// ===== src/cfip_pkg.sv =====
// Package for the clamped float integer power block.
// Holds widths, constants, the queue entry type and the back-end state type.
`timescale 1ns / 1ps
package cfip_pkg;
  localparam int unsigned ExpMax = 255;
  localparam int unsigned PowW = 8;
  localparam logic [31:0] OneBits = 32'h3F80_0000;
  localparam logic [31:0] LimitReset = 32'h411F_FFFF;
  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = 1;

  typedef enum logic [1:0] {
    CLS_ONE,
    CLS_NAN,
    CLS_MUL
  } cls_t;

  typedef struct packed {
    logic [31:0]     base;
    logic [PowW-1:0] count;
    logic            last;
    cls_t            cls;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_RND,
    BK_DONE
  } bk_state_t;

  function automatic logic is_nan(input logic [31:0] b);
    is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Ordered greater-than on IEEE singles; false when either side is NaN.
  function automatic logic f_gt(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      res = 1'b0;
    end else if (!a[31] && b[31]) begin
      res = 1'b1;
    end else if (a[31] && !b[31]) begin
      res = 1'b0;
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    f_gt = res;
  endfunction
endpackage

// ===== src/cfip_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Depends on nothing but the timescale.
`timescale 1ns / 1ps
interface cfip_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] base_bits;
  logic [7:0]  power;
  logic        final_element;
  modport source (output valid, base_bits, power, final_element, input ready);
  modport sink (input valid, base_bits, power, final_element, output ready);
endinterface

interface cfip_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        final_result;
  modport source (output valid, result_bits, final_result, input ready);
  modport sink (input valid, result_bits, final_result, output ready);
endinterface

// ===== src/cfip_front.sv =====
// Front end: accepts input transactions, saturates the exponent and classifies.
// Depends on cfip_pkg.
`timescale 1ns / 1ps
module cfip_front (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_base_bits,
  input  logic [7:0]         in_power,
  input  logic               in_final_element,
  output logic               push,
  output cfip_pkg::entry_t   push_data,
  input  logic               q_full
);
  logic [cfip_pkg::PowW-1:0] cnt;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cnt = (32'(in_power) > cfip_pkg::ExpMax) ? cfip_pkg::PowW'(cfip_pkg::ExpMax) : in_power;
    push_data.base  = in_base_bits;
    push_data.count = cnt;
    push_data.last  = in_final_element;
    if (cnt == '0) begin
      push_data.cls = cfip_pkg::CLS_ONE;
    end else if (cfip_pkg::is_nan(in_base_bits)) begin
      push_data.cls = cfip_pkg::CLS_NAN;
    end else begin
      push_data.cls = cfip_pkg::CLS_MUL;
    end
  end
endmodule

// ===== src/cfip_queue.sv =====
// Short FIFO between the front and back ends, held in registers.
// Depends on cfip_pkg.
`timescale 1ns / 1ps
module cfip_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfip_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output cfip_pkg::entry_t pop_data,
  output logic             not_empty
);
  cfip_pkg::entry_t mem_r [cfip_pkg::QDepth];
  logic [cfip_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [cfip_pkg::QPtrW:0] cnt_r;

  assign full      = cnt_r == (cfip_pkg::QPtrW+1)'(cfip_pkg::QDepth);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (cfip_pkg::QPtrW+1)'(push) - (cfip_pkg::QPtrW+1)'(pop);
    end
  end
endmodule

// ===== src/cfip_back.sv =====
// Back end: repeated IEEE single multiply with round-to-nearest-even,
// clamping and an output register. Depends on cfip_pkg.
`timescale 1ns / 1ps
module cfip_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      clamp_limit,
  input  logic             q_valid,
  input  cfip_pkg::entry_t q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_result_bits,
  output logic             out_final_result
);
  cfip_pkg::bk_state_t st_r, st_nxt;
  logic [31:0] base_r, acc_r, acc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        last_r;
  logic [47:0] prod_r;
  logic        sgn_r;
  logic signed [10:0] pexp_r;
  logic        spec_r;
  logic [31:0] spec_val_r;
  logic [31:0] res_r;
  logic        fin_r;

  // Unpacked operands (combinational, before the multiplier register).
  logic [23:0] ma, mb;
  logic signed [10:0] ea, eb;
  logic a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [31:0] spec_v;
  logic        spec_c;

  always_comb begin
    a_nan  = cfip_pkg::is_nan(acc_r);
    b_nan  = cfip_pkg::is_nan(base_r);
    a_inf  = acc_r[30:0] == 31'h7F80_0000;
    b_inf  = base_r[30:0] == 31'h7F80_0000;
    a_zero = acc_r[30:0] == 31'd0;
    b_zero = base_r[30:0] == 31'd0;
    ma = {acc_r[30:23] != 8'd0, acc_r[22:0]};
    mb = {base_r[30:23] != 8'd0, base_r[22:0]};
    ea = (acc_r[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, acc_r[30:23]});
    eb = (base_r[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, base_r[30:23]});
    spec_c = 1'b1;
    spec_v = '0;
    if (a_nan) begin
      spec_v = acc_r | cfip_pkg::QuietBit;
    end else if (b_nan) begin
      spec_v = base_r | cfip_pkg::QuietBit;
    end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
      spec_v = 32'h7FC0_0000;
    end else if (a_inf || b_inf) begin
      spec_v = {acc_r[31] ^ base_r[31], 31'h7F80_0000};
    end else if (a_zero || b_zero) begin
      spec_v = {acc_r[31] ^ base_r[31], 31'd0};
    end else begin
      spec_c = 1'b0;
    end
  end

  // Normalize and round the registered product.
  logic [5:0]  lz;
  logic [47:0] nm;
  logic signed [11:0] e1;
  logic [49:0] sh;
  logic [23:0] man;
  logic        g, stk, rup;
  logic [24:0] mr;
  logic signed [11:0] ef;
  logic [31:0] rnd;
  logic [6:0]  rs;

  always_comb begin
    lz = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (prod_r[i]) begin
        lz = 6'(47 - i);
      end
    end
    nm = prod_r << lz;
    // Value = nm[47].nm[46:0] * 2^(pexp - 127 - 127 + 1 - lz), biased exponent:
    e1 = 12'(pexp_r) - 12'sd126 - 12'(lz);
    sh = {nm, 2'b00};
    if (e1 < 12'sd1) begin
      rs = (12'sd1 - e1 > 12'sd50) ? 7'd50 : 7'(12'sd1 - e1);
      sh = ({nm, 2'b00} >> rs);
      stk = |({nm, 2'b00} & ~({50{1'b1}} << rs));
      ef = 12'sd0;
    end else begin
      rs = 7'd0;
      stk = 1'b0;
      ef = e1;
    end
    man = sh[49:26];
    g   = sh[25];
    stk = stk | (|sh[24:0]);
    rup = g && (stk || man[0]);
    mr  = {1'b0, man} + 25'(rup);
    if (mr[24]) begin
      ef = ef + 12'sd1;
      mr = mr >> 1;
    end else if (ef == 12'sd0 && mr[23]) begin
      ef = 12'sd1;
    end
    if (ef >= 12'sd255) begin
      rnd = {sgn_r, 31'h7F80_0000};
    end else begin
      rnd = {sgn_r, ef[7:0], mr[22:0]};
    end
  end

  logic [31:0] step_res;
  assign step_res = spec_r ? spec_val_r : rnd;

  assign out_valid        = st_r == cfip_pkg::BK_DONE;
  assign out_result_bits  = res_r;
  assign out_final_result = fin_r;

  // Items without work skip straight to the result.
  always_comb begin
    st_nxt   = st_r;
    pop      = 1'b0;
    acc_nxt  = acc_r;
    left_nxt = left_r;
    case (st_r)
      cfip_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          st_nxt = (q_data.cls == cfip_pkg::CLS_MUL) ? cfip_pkg::BK_MUL : cfip_pkg::BK_DONE;
        end
      end
      cfip_pkg::BK_MUL: begin
        st_nxt = cfip_pkg::BK_RND;
      end
      cfip_pkg::BK_RND: begin
        acc_nxt  = step_res;
        left_nxt = left_r - 8'd1;
        st_nxt   = (left_r == 8'd1) ? cfip_pkg::BK_DONE : cfip_pkg::BK_MUL;
      end
      cfip_pkg::BK_DONE: begin
        if (out_ready) begin
          st_nxt = cfip_pkg::BK_IDLE;
        end
      end
      default: st_nxt = cfip_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cfip_pkg::BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    left_r <= left_nxt;
    if (st_r == cfip_pkg::BK_IDLE && q_valid) begin
      base_r <= q_data.base;
      left_r <= q_data.count;
      last_r <= q_data.last;
      acc_r  <= cfip_pkg::OneBits;
      fin_r  <= q_data.last;
      case (q_data.cls)
        cfip_pkg::CLS_ONE: begin
          res_r <= cfip_pkg::OneBits;
        end
        cfip_pkg::CLS_NAN: begin
          res_r <= q_data.base | cfip_pkg::QuietBit;
        end
        default: begin
          res_r <= res_r;
        end
      endcase
      if (q_data.cls != cfip_pkg::CLS_MUL) begin
        left_r <= 8'd0;
      end
    end
    if (st_r == cfip_pkg::BK_MUL) begin
      prod_r     <= 48'(ma) * 48'(mb);
      sgn_r      <= acc_r[31] ^ base_r[31];
      pexp_r     <= ea + eb;
      spec_r     <= spec_c;
      spec_val_r <= spec_v;
    end
    if (st_r == cfip_pkg::BK_RND && left_r == 8'd1) begin
      fin_r <= last_r;
      res_r <= step_res;
      if (!cfip_pkg::is_nan(step_res) && cfip_pkg::f_gt(step_res, clamp_limit)) begin
        res_r <= clamp_limit;
      end
    end
  end
endmodule

// ===== src/clamped_float_integer_power_top.sv =====
// Top level of the clamped float integer power block.
// Depends on cfip_pkg, cfip_if, cfip_front, cfip_queue and cfip_back.
//
//   channel  direction  payload                           handshake
//   in       sink       base_bits, power, final_element   valid / ready
//   out      source     result_bits, final_result         valid / ready
//   cfg      sink       clamp_limit (32 bits)             write enable
//
// An item with a zero exponent or a NaN base skips the multiplier in the back end.
// Any other item passes through the one shared multiplier and its
// normalize/round step once per exponent count.
// The front end takes one transaction per cycle, unless the two-entry queue
// is full, so inputs are accepted while the back end works or its result waits.
// Reset is synchronous and active low; it empties the queue, idles the back
// end and loads the clamp limit with 9.999999.
`timescale 1ns / 1ps
module clamped_float_integer_power_top (
  input  logic        clk,
  input  logic        rst_n,
  cfip_in_if.sink     in_ch,
  cfip_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  logic [31:0] clamp_limit_r;
  logic push, q_full, pop, q_ne;
  cfip_pkg::entry_t push_data, pop_data;

  // The user must rewrite the clamp limit only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_limit_r <= cfip_pkg::LimitReset;
    end else if (cfg_we) begin
      clamp_limit_r <= cfg_wdata;
    end
  end

  cfip_front u_front (
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_base_bits(in_ch.base_bits), .in_power(in_ch.power),
    .in_final_element(in_ch.final_element),
    .push, .push_data, .q_full
  );

  cfip_queue u_queue (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .pop_data, .not_empty(q_ne)
  );

  cfip_back u_back (
    .clk, .rst_n, .clamp_limit(clamp_limit_r),
    .q_valid(q_ne), .q_data(pop_data), .pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result_bits(out_ch.result_bits), .out_final_result(out_ch.final_result)
  );
endmodule

// ===== src/cfip_checker.sv =====
// Port-level checker for the clamped float integer power block, with its bind.
// Depends on cfip_if and the top level's ports.
`timescale 1ns / 1ps
module cfip_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_power,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_bits
);
  // A result waiting for the sink holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_bits))
    else $error("result changed while stalled");

  // No result appears in the cycle right after reset.
  assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result right after reset");

  // A waiting result stays offered until the sink takes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");
endmodule

bind clamped_float_integer_power_top cfip_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_power(in_ch.power),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result_bits(out_ch.result_bits)
);

// ===== dv/power_checker.sv =====
// Checker for the clamped float integer power block: watches both channels and
// the clamp-limit write port, predicts every result and compares it.
// Depends on cfip_pkg and the channel interfaces in cfip_if.
`timescale 1ns / 1ps
module power_checker (
  input  logic        clk,
  input  logic        rst_n,
  cfip_in_if          in_ch,
  cfip_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          clamped
);
  typedef struct {
    logic [31:0] bits;
    logic        last;
  } power_result_t;

  power_result_t expected_powers[$];
  logic [31:0]   limit_mirror;

  function automatic logic sp_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  // Ordered greater-than; any NaN operand compares false, and +0 equals -0.
  function automatic logic sp_greater(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if (sp_is_nan(a) || sp_is_nan(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka > kb;
  endfunction

  // Single-precision multiply, round to nearest even, subnormals kept.
  // NaN operands never reach it, and zero times infinity cannot arise.
  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        sgn;
    int          ea;
    int          eb;
    int          p;
    int          er;
    int          s;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    logic [63:0] sig;
    logic        guard;
    logic        sticky;
    sgn = a[31] ^ b[31];
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {sgn, 8'hFF, 23'd0};
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
    ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
    ma = {40'd0, a[30:23] != 8'd0, a[22:0]};
    mb = {40'd0, b[30:23] != 8'd0, b[22:0]};
    m = ma * mb;
    p = 63;
    while (!m[p]) p--;
    er = ea + eb + p - 173;
    if (er < 1) er = 1;
    s = er + 150 - ea - eb;
    guard = 1'b0;
    sticky = 1'b0;
    if (s <= 0) begin
      sig = m << (-s);
    end else if (s >= 64) begin
      sig = 64'd0;
      sticky = 1'b1;
    end else begin
      sig = m >> s;
      guard = m[s-1];
      sticky = (s > 1) && ((m & ((64'd1 << (s - 1)) - 64'd1)) != 64'd0);
    end
    if (guard && (sticky || sig[0])) sig = sig + 64'd1;
    if (sig[24]) begin
      sig = sig >> 1;
      er++;
    end
    if (er >= 255) return {sgn, 8'hFF, 23'd0};
    if (!sig[23]) return {sgn, 8'd0, sig[22:0]};
    return {sgn, 8'(er), sig[22:0]};
  endfunction

  function automatic logic [31:0] predict_power(input logic [31:0] base,
                                                input logic [7:0] power,
                                                input logic [31:0] limit);
    logic [31:0] acc;
    int          n;
    n = (int'(power) > int'(cfip_pkg::ExpMax)) ? int'(cfip_pkg::ExpMax) : int'(power);
    if (n == 0) return cfip_pkg::OneBits;
    if (sp_is_nan(base)) return base | cfip_pkg::QuietBit;
    acc = cfip_pkg::OneBits;
    for (int i = 0; i < n; i++) acc = sp_mul(acc, base);
    if (!sp_is_nan(acc) && sp_greater(acc, limit)) acc = limit;
    return acc;
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
    checked = 0;
    clamped = 0;
    limit_mirror = cfip_pkg::LimitReset;
  end

  always @(posedge clk) begin
    power_result_t want;
    power_result_t fresh;
    if (!rst_n) begin
      expected_powers.delete();
      limit_mirror = cfip_pkg::LimitReset;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_powers.size() == 0) begin
          $error("result transaction with no expectation: result_bits=%h",
                 out_ch.result_bits);
          mismatches++;
        end else begin
          want = expected_powers.pop_front();
          checked++;
          if (out_ch.result_bits !== want.bits) begin
            $error("result_bits expected %h actual %h", want.bits, out_ch.result_bits);
            mismatches++;
          end
          if (out_ch.final_result !== want.last) begin
            $error("final_result expected %b actual %b", want.last, out_ch.final_result);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        fresh.bits = predict_power(in_ch.base_bits, in_ch.power, limit_mirror);
        fresh.last = in_ch.final_element;
        if (in_ch.power != 8'd0 && !sp_is_nan(in_ch.base_bits) && fresh.bits == limit_mirror)
          clamped++;
        expected_powers.push_back(fresh);
      end
      if (cfg_we) limit_mirror = cfg_wdata;
    end
    pending = expected_powers.size();
  end
endmodule

// ===== dv/tb.sv =====
// Testbench top for the clamped float integer power block.
// Depends on cfip_pkg, cfip_if, the block's RTL and power_checker.
`timescale 1ns / 1ps
module tb;
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          mismatches;
  int          pending;
  int          checked;
  int          clamped;
  int          sent;
  int          settings;
  bit          hold_req;
  bit          no_idle;

  cfip_in_if  in_ch();
  cfip_out_if out_ch();

  clamped_float_integer_power_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  power_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .clamped    (clamped)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bases: values near one make long powers land near the clamp limit, the
  // special encodings hit every class, and raw random words cover every bit.
  function automatic logic [31:0] pick_base();
    logic [31:0] specials[12];
    int          r;
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7F80_0001, 32'hFFC0_1234, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F7F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h4000_0000};
    r = $urandom_range(99);
    if (r < 45) return {1'($urandom), 8'($urandom_range(124, 130)), 23'($urandom)};
    if (r < 60) return specials[$urandom_range(11)];
    return $urandom;
  endfunction

  // Exponents stay small most of the time since each count costs a multiply and round step.
  function automatic logic [7:0] pick_power();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 8'($urandom_range(0, 6));
    if (r < 82) return 8'($urandom_range(7, 40));
    if (r < 96) return 8'($urandom_range(41, 254));
    return 8'd255;
  endfunction

  // Offers one transaction after an optional gap and returns at the edge
  // where it is taken. valid stays high between back-to-back transactions.
  task automatic send_power(input logic [31:0] base, input logic [7:0] power,
                            input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.base_bits <= base;
    in_ch.power <= power;
    in_ch.final_element <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // The limit register is only rewritten once every result has drained, so
  // the block never holds a transaction that was predicted with the old value.
  task automatic write_limit(input logic [31:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Result side: random stretches of ready high and low. On request it holds
  // off for a long run so the queue fills and the input stalls.
  initial begin
    int len;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (1200) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        len = $urandom_range(99);
        if (no_idle || len < 55) begin
          out_ch.ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (len < 92) begin
          out_ch.ready <= 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          out_ch.ready <= 1'b0;
          len = $urandom_range(20, 80);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] limits[8];
    limits = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
               32'h7F7F_FFFF, 32'h8000_0000, 32'h4120_0000, 32'h0};
    sent = 0;
    settings = 1;
    hold_req = 1'b0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 32'd0;
    in_ch.valid <= 1'b0;
    in_ch.base_bits <= 32'd0;
    in_ch.power <= 8'd0;
    in_ch.final_element <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset limit of 9.999999.
    send_power(32'h7FC0_0000, 8'd0, 1'b0);   // zero exponent wins over a NaN base
    send_power(32'h4000_0000, 8'd0, 1'b1);   // zero exponent gives one
    send_power(32'h7F80_0001, 8'd3, 1'b0);   // signaling NaN comes back quieted
    send_power(32'hFFC0_1234, 8'd1, 1'b1);   // negative quiet NaN keeps payload
    send_power(32'h3F80_0000, 8'd255, 1'b0); // largest exponent on one
    send_power(32'h4000_0000, 8'd3, 1'b0);   // eight, below the limit
    send_power(32'h4000_0000, 8'd4, 1'b1);   // sixteen, clamped
    send_power(32'hC000_0000, 8'd4, 1'b0);   // positive sixteen, clamped
    send_power(32'hC000_0000, 8'd5, 1'b0);   // negative, never clamped
    send_power(32'h0000_0001, 8'd1, 1'b0);   // smallest subnormal
    send_power(32'h0000_0001, 8'd2, 1'b1);   // underflows to zero
    send_power(32'h007F_FFFF, 8'd1, 1'b0);   // largest subnormal
    send_power(32'h7F7F_FFFF, 8'd2, 1'b0);   // overflow to infinity, clamped
    send_power(32'hFF7F_FFFF, 8'd3, 1'b0);   // negative overflow
    send_power(32'h7F80_0000, 8'd1, 1'b1);   // infinity, clamped
    send_power(32'hFF80_0000, 8'd3, 1'b0);   // negative infinity stays
    send_power(32'h0000_0000, 8'd5, 1'b0);   // zero base
    send_power(32'h8000_0000, 8'd3, 1'b0);   // negative zero base
    send_power(32'h3F00_0000, 8'd255, 1'b1); // one half to the 255th underflows
    send_power(32'h3F80_0001, 8'd255, 1'b0); // rounding drift near one
    send_power(32'h4120_0000, 8'd1, 1'b1);   // ten, just above the limit

    // Random phases, each under its own limit; the first keeps the reset value.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph > 0) write_limit((ph == 8) ? $urandom : limits[ph-1]);
      if (ph == 3) hold_req = 1'b1;
      no_idle = (ph == 5);
      for (int k = 0; k < 100; k++) send_power(pick_base(), pick_power(), 1'($urandom));
    end
    no_idle = 1'b0;

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (600) @(posedge clk);

    $display("Run covered %0d input transactions over %0d clamp-limit settings;",
             sent, settings);
    $display("%0d results compared, %0d of them clamped.", checked, clamped);
    if (mismatches == 0 && pending == 0) begin
      $display("clamped_float_integer_power_top verification clean");
    end else begin
      $display("clamped_float_integer_power_top verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run; reaching it means the block hung.
  initial begin
    #20_000_000;
    $display("clamped_float_integer_power_top verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/cfip_pkg.sv
src/cfip_if.sv
src/cfip_front.sv
src/cfip_queue.sv
src/cfip_back.sv
src/clamped_float_integer_power_top.sv
src/cfip_checker.sv
dv/power_checker.sv
dv/tb.sv
